// ----- rtl/srw_pkg.sv -----
// Shared types and constants of the selective-repeat receive window.
package srw_pkg;

    // Field widths fixed by the frame and result formats
    localparam int CFG_W  = 6;
    localparam int SEQ_W  = 8;
    localparam int BYTE_W = 8;
    localparam int ACK_W  = 9;
    localparam int ADV_W  = 5;

    // Window size after reset
    localparam logic [CFG_W-1:0] WIN_RESET = 6'd4;

    // Result kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_ACK  = 1'b1;

    // One classified frame as it waits in the queue
    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [BYTE_W-1:0] payload;
        logic              in_space;
        logic [CFG_W-1:0]  win;
    } srw_item_t;

    // Queue head as the back end sees it
    typedef struct packed {
        logic      valid;
        srw_item_t item;
    } srw_q_t;

    // Back end control toward the front end
    typedef struct packed {
        logic pop;
        logic clearing;
    } srw_ctl_t;

endpackage

// ----- rtl/srw_if.sv -----
// Request channels: received frames in, delivered bytes and acks out.
interface srw_frame_if
    import srw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SEQ_W-1:0]  seq_num;
    logic [BYTE_W-1:0] payload;

    modport source (output valid, seq_num, payload, input ready);
    modport sink   (input valid, seq_num, payload, output ready);
endinterface

interface srw_result_if
    import srw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [BYTE_W-1:0] data_byte;
    logic [ACK_W-1:0]  ack_num;
    logic [ADV_W-1:0]  adv_window;
    logic              duplicate;
    logic              last;

    modport source (output valid, kind, data_byte, ack_num, adv_window, duplicate, last,
                    input ready);
    modport sink   (input valid, kind, data_byte, ack_num, adv_window, duplicate, last,
                    output ready);
endinterface

// ----- rtl/srw_front.sv -----
// Front end: accepts frames, classifies them and queues them for the back end.
module srw_front
    import srw_pkg::*;
#(
    parameter int SEQ_SPACE  = 256,
    parameter int MAX_WINDOW = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CFG_W-1:0] win_cfg,
    srw_frame_if.sink        in_frame,
    output srw_q_t           q_out,
    input  srw_ctl_t         ctl
);

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    srw_item_t             queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  push;
    logic                  pop;
    logic [CFG_W-1:0]      eff_win;
    srw_item_t             new_item;

    // Clamp the window size into its legal range
    always_comb
    begin
        eff_win = win_cfg;
        if (win_cfg == '0)
        begin
            eff_win = CFG_W'(1);
        end
        else if ({26'd0, win_cfg} > 32'(MAX_WINDOW))
        begin
            eff_win = CFG_W'(MAX_WINDOW);
        end
    end

    // Classify the incoming frame
    always_comb
    begin
        new_item.seq      = in_frame.seq_num;
        new_item.payload  = in_frame.payload;
        new_item.in_space = ({24'd0, in_frame.seq_num} < 32'(SEQ_SPACE));
        new_item.win      = eff_win;
    end

    // Hold off requests while the queue is full or the map is being cleared
    assign in_frame.ready = (count_reg != CNT_W'(QUEUE_DEPTH)) && !ctl.clearing;
    assign push           = in_frame.valid && in_frame.ready;
    assign pop            = ctl.pop && (count_reg != '0);

    assign q_out.valid = (count_reg != '0);
    assign q_out.item  = queue_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the classified request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ----- rtl/srw_back.sv -----
// Back end: marks frames, searches the window and delivers bytes and the ack.
module srw_back
    import srw_pkg::*;
#(
    parameter int SEQ_SPACE  = 256,
    parameter int MAX_WINDOW = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  srw_q_t       q_in,
    output srw_ctl_t     ctl,
    srw_result_if.source out_result
);

    localparam int AW = $clog2(SEQ_SPACE);
    localparam int EW = $clog2(SEQ_SPACE + 1);
    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam int SW = ((EW > WW) ? EW : WW) + 1;

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_CHECK    = 4'd2;
    localparam logic [3:0] ST_MARK     = 4'd3;
    localparam logic [3:0] ST_SCAN     = 4'd4;
    localparam logic [3:0] ST_SCAN_CHK = 4'd5;
    localparam logic [3:0] ST_DLV_RD   = 4'd6;
    localparam logic [3:0] ST_DLV_OUT  = 4'd7;
    localparam logic [3:0] ST_ACK      = 4'd8;

    // Received map and frame store
    logic              map_mem   [SEQ_SPACE];
    logic [BYTE_W-1:0] store_mem [SEQ_SPACE];

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [AW-1:0]     clr_cnt_reg;
    logic [AW-1:0]     clr_cnt_next;
    srw_item_t         job_reg;
    srw_item_t         job_next;
    logic              dup_reg;
    logic              dup_next;
    logic [EW-1:0]     edge_reg;
    logic [EW-1:0]     edge_next;
    logic [WW-1:0]     cnt_reg;
    logic [WW-1:0]     cnt_next;
    logic [WW-1:0]     dlv_reg;
    logic [WW-1:0]     dlv_next;
    logic              map_rd_reg;
    logic [BYTE_W-1:0] store_rd_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_kind_reg;
    logic              out_kind_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [BYTE_W-1:0] out_byte_next;
    logic [ACK_W-1:0]  out_ack_reg;
    logic [ACK_W-1:0]  out_ack_next;
    logic [ADV_W-1:0]  out_adv_reg;
    logic [ADV_W-1:0]  out_adv_next;
    logic              out_dup_reg;
    logic              out_dup_next;
    logic              out_last_reg;
    logic              out_last_next;

    logic [WW-1:0]     offset;
    logic [SW-1:0]     pos_sum;
    logic              pos_end;
    logic [WW-1:0]     win_w;
    logic [AW-1:0]     rd_addr;
    logic              rd_en;
    logic              map_we;
    logic [AW-1:0]     map_wa;
    logic              map_wd;
    logic              store_we;
    logic              out_free;

    // Position in the window: scan count, or delivery count while reading bytes
    assign offset  = (state_reg == ST_DLV_RD) ? dlv_reg : cnt_reg;
    assign pos_sum = SW'(edge_reg) + SW'(offset);
    assign pos_end = (pos_sum >= SW'(SEQ_SPACE));
    assign win_w   = WW'(job_reg.win);
    assign rd_addr = (state_reg == ST_CHECK) ? AW'(job_reg.seq) : AW'(pos_sum);
    assign rd_en   = (state_reg == ST_CHECK) || (state_reg == ST_SCAN) ||
                     (state_reg == ST_DLV_RD);
    assign out_free = !out_valid_reg || out_result.ready;

    // Select the memory write: clearing pass or marking a new frame
    always_comb
    begin
        map_we   = 1'b0;
        map_wa   = AW'(job_reg.seq);
        map_wd   = 1'b1;
        store_we = 1'b0;
        if (state_reg == ST_CLEAR)
        begin
            map_we = 1'b1;
            map_wa = clr_cnt_reg;
            map_wd = 1'b0;
        end
        else if ((state_reg == ST_MARK) && job_reg.in_space && !map_rd_reg)
        begin
            map_we   = 1'b1;
            store_we = 1'b1;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        job_next       = job_reg;
        dup_next       = dup_reg;
        edge_next      = edge_reg;
        cnt_next       = cnt_reg;
        dlv_next       = dlv_reg;
        ctl.pop        = 1'b0;
        ctl.clearing   = (state_reg == ST_CLEAR);
        out_valid_next = out_valid_reg && !out_result.ready;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_ack_next   = out_ack_reg;
        out_adv_next   = out_adv_reg;
        out_dup_next   = out_dup_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(SEQ_SPACE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_in.valid)
                begin
                    ctl.pop    = 1'b1;
                    job_next   = q_in.item;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = ST_MARK;
            end
            ST_MARK:
            begin
                dup_next   = job_reg.in_space && map_rd_reg;
                cnt_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // Stop at the window's end or the end of the sequence space
                if ((cnt_reg == win_w) || pos_end)
                begin
                    dlv_next   = '0;
                    state_next = ST_DLV_RD;
                end
                else
                begin
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                if (map_rd_reg)
                begin
                    cnt_next   = cnt_reg + WW'(1);
                    state_next = ST_SCAN;
                end
                else
                begin
                    dlv_next   = '0;
                    state_next = ST_DLV_RD;
                end
            end
            ST_DLV_RD:
            begin
                state_next = (dlv_reg == cnt_reg) ? ST_ACK : ST_DLV_OUT;
            end
            ST_DLV_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_BYTE;
                    out_byte_next  = store_rd_reg;
                    out_ack_next   = ACK_W'(pos_sum);
                    out_adv_next   = ADV_W'(job_reg.win - CFG_W'(1));
                    out_dup_next   = dup_reg;
                    out_last_next  = 1'b0;
                    dlv_next       = dlv_reg + WW'(1);
                    state_next     = ST_DLV_RD;
                end
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ACK;
                    out_byte_next  = '0;
                    out_ack_next   = ACK_W'(pos_sum);
                    out_adv_next   = ADV_W'(job_reg.win - CFG_W'(1));
                    out_dup_next   = dup_reg;
                    out_last_next  = 1'b1;
                    edge_next      = EW'(pos_sum);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            edge_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            edge_reg      <= edge_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Job and result payload
    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        dup_reg      <= dup_next;
        cnt_reg      <= cnt_next;
        dlv_reg      <= dlv_next;
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_ack_reg  <= out_ack_next;
        out_adv_reg  <= out_adv_next;
        out_dup_reg  <= out_dup_next;
        out_last_reg <= out_last_next;
    end

    // Memory write port and registered read port
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_wa] <= map_wd;
        end
        if (store_we)
        begin
            store_mem[map_wa] <= job_reg.payload;
        end
        if (rd_en)
        begin
            map_rd_reg   <= map_mem[rd_addr];
            store_rd_reg <= store_mem[rd_addr];
        end
    end

    assign out_result.valid      = out_valid_reg;
    assign out_result.kind       = out_kind_reg;
    assign out_result.data_byte  = out_byte_reg;
    assign out_result.ack_num    = out_ack_reg;
    assign out_result.adv_window = out_adv_reg;
    assign out_result.duplicate  = out_dup_reg;
    assign out_result.last       = out_last_reg;

endmodule

// ----- rtl/selective_repeat_receive_window.sv -----
// Top level of the selective-repeat receive window.
// Each request on in_frame is one received frame; the block marks it in a
// received map, flags a repeat as duplicate, moves the left window edge to the
// first slot not yet received, within the window and the sequence space, and then
// emits the passed-over bytes in order, followed by one ack carrying the new edge
// and the window width minus one. The received map and frame store share one read
// port, so each window slot costs one read and one check while searching and one
// read and one output while delivering. A two-entry queue in front lets frames
// arrive while a previous one is still being worked off. After reset the received
// map is cleared one entry per cycle with in_frame.ready low; window register
// writes are taken during that time. Write the window register only while the
// block is idle.
module selective_repeat_receive_window
    import srw_pkg::*;
#(
    parameter int SEQ_SPACE  = 256,
    parameter int MAX_WINDOW = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    srw_frame_if.sink        in_frame,
    srw_result_if.source     out_result
);

    logic [CFG_W-1:0] win_cfg_reg;
    logic [CFG_W-1:0] win_cfg_next;
    srw_q_t           q_head;
    srw_ctl_t         back_ctl;

    // Capture the window size register
    assign win_cfg_next = cfg_we ? cfg_wdata : win_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_cfg_reg <= WIN_RESET;
        end
        else
        begin
            win_cfg_reg <= win_cfg_next;
        end
    end

    srw_front #(
        .SEQ_SPACE  (SEQ_SPACE),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .win_cfg     (win_cfg_reg),
        .in_frame    (in_frame),
        .q_out       (q_head),
        .ctl         (back_ctl)
    );

    srw_back #(
        .SEQ_SPACE  (SEQ_SPACE),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_in       (q_head),
        .ctl        (back_ctl),
        .out_result (out_result)
    );

endmodule

// ----- rtl/srw_checker.sv -----
// Port-level checks of the receive window, bound to the top level.
module srw_checker
    import srw_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic              kind,
    input logic [BYTE_W-1:0] data_byte,
    input logic [ACK_W-1:0]  ack_num,
    input logic [ADV_W-1:0]  adv_window,
    input logic              duplicate,
    input logic              last
);

    // Hold a stalled result request unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_byte) &&
        $stable(ack_num) && $stable(adv_window) && $stable(duplicate) && $stable(last))
        else $error("stalled result changed");

    // Only the ack closes a frame's results
    a_last_is_ack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (kind == KIND_ACK)))
        else $error("last does not match ack kind");

    // Drive a zero data byte on the ack
    a_ack_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_ACK) |-> (data_byte == '0))
        else $error("ack carries a data byte");

    // A delivered byte means the edge has moved past slot zero
    a_byte_edge: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_BYTE) |-> (ack_num != '0))
        else $error("byte delivered with edge at zero");

endmodule

bind selective_repeat_receive_window srw_checker u_srw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_result.valid),
    .out_ready  (out_result.ready),
    .kind       (out_result.kind),
    .data_byte  (out_result.data_byte),
    .ack_num    (out_result.ack_num),
    .adv_window (out_result.adv_window),
    .duplicate  (out_result.duplicate),
    .last       (out_result.last)
);

// ----- test/selective_repeat_receive_window_test.sv -----
// Testbench of the selective-repeat receive window: predicted deliveries and acks per frame.
`timescale 1ns / 1ps

module selective_repeat_receive_window_test;
    import srw_pkg::*;

    localparam int SPACE     = 256;
    localparam int WIN_MAX   = 32;
    localparam int HOLD_LEN  = 400;
    localparam int SETTLE    = 200;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [BYTE_W-1:0] payload;
    } frame_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
        logic [ACK_W-1:0]  ack_num;
        logic [ADV_W-1:0]  adv_window;
        logic              duplicate;
        logic              last;
    } window_out_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    srw_frame_if  frame_ch ();
    srw_result_if result_ch ();

    // Frames waiting to be offered, and the deliveries they are predicted to cause
    frame_t      frame_q [$];
    window_out_t window_out_q [$];

    // Receiver state as predicted
    bit               seen_map [0:SPACE-1];
    logic [7:0]       byte_store [0:SPACE-1];
    int               rx_edge;
    logic [CFG_W-1:0] window_copy;

    // Generator shadow: which sequence numbers were already queued
    bit sent_map [0:SPACE-1];
    int low_free;

    int     error_count;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_requests;
    int     hold_served;
    int     hold_left;
    logic   frame_taken;
    frame_t next_frame;

    selective_repeat_receive_window i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_frame   (frame_ch),
        .out_result (result_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int eff_window(input logic [CFG_W-1:0] w);
        int v;
        v = int'(w);
        if (v == 0)
            v = 1;
        if (v > WIN_MAX)
            v = WIN_MAX;
        return v;
    endfunction

    function automatic string fmt_out(input window_out_t r);
        return $sformatf("kind=%0d byte=%02h ack=%0d adv=%0d dup=%0d last=%0d",
                         r.kind, r.data_byte, r.ack_num, r.adv_window, r.duplicate, r.last);
    endfunction

    // Mark the frame, slide the left edge and queue the passed bytes plus the ack
    task automatic advance_window(input logic [SEQ_W-1:0] seq, input logic [BYTE_W-1:0] pay);
        int          w;
        int          e_old;
        int          e_new;
        int          p;
        logic        dup;
        window_out_t r;
        w   = eff_window(window_copy);
        dup = seen_map[seq];
        if (!dup)
        begin
            seen_map[seq]   = 1'b1;
            byte_store[seq] = pay;
        end
        e_old = rx_edge;
        e_new = e_old + w;
        for (p = e_old; p < e_old + w; p++)
        begin
            if (p >= SPACE)
            begin
                e_new = SPACE;
                break;
            end
            if (!seen_map[p])
            begin
                e_new = p;
                break;
            end
        end
        if (e_new > SPACE)
            e_new = SPACE;
        rx_edge = e_new;
        for (p = e_old; p < e_new; p++)
        begin
            r.kind       = KIND_BYTE;
            r.data_byte  = byte_store[p];
            r.ack_num    = ACK_W'(e_new);
            r.adv_window = ADV_W'(w - 1);
            r.duplicate  = dup;
            r.last       = 1'b0;
            window_out_q.push_back(r);
        end
        r.kind       = KIND_ACK;
        r.data_byte  = '0;
        r.ack_num    = ACK_W'(e_new);
        r.adv_window = ADV_W'(w - 1);
        r.duplicate  = dup;
        r.last       = 1'b1;
        window_out_q.push_back(r);
    endtask

    // Capture accepted frame requests and predict their results
    always @(posedge clk)
    begin
        frame_taken = rst_n && frame_ch.valid && frame_ch.ready;
        if (frame_taken)
            advance_window(frame_ch.seq_num, frame_ch.payload);
    end

    // Offer the next frame once the current one is taken, idling at random
    always @(negedge clk)
    begin
        if (rst_n && (!frame_ch.valid || frame_taken))
        begin
            if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_frame = frame_q.pop_front();
                frame_ch.valid   <= 1'b1;
                frame_ch.seq_num <= next_frame.seq;
                frame_ch.payload <= next_frame.payload;
            end
            else
                frame_ch.valid <= 1'b0;
        end
    end

    // Count down a long receiver hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left--;
        else if (hold_served != hold_requests)
        begin
            hold_left = HOLD_LEN;
            hold_served++;
        end
    end

    // Drive result ready: stall at random, drop it during a hold-off
    always @(negedge clk)
    begin
        result_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // Check each accepted result request against the oldest prediction
    always @(posedge clk)
    begin
        window_out_t got;
        window_out_t want;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready)
        begin
            got = {result_ch.kind, result_ch.data_byte, result_ch.ack_num,
                   result_ch.adv_window, result_ch.duplicate, result_ch.last};
            if (window_out_q.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, got %s", $time, fmt_out(got));
            end
            else
            begin
                want = window_out_q.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    $display("%0t: mismatch, expected %s, got %s",
                             $time, fmt_out(want), fmt_out(got));
                end
            end
        end
    end

    // Queue one frame and track the lowest sequence number not yet queued
    task automatic queue_frame(input int seq, input int pay);
        frame_t f;
        f.seq     = SEQ_W'(seq);
        f.payload = BYTE_W'(pay);
        frame_q.push_back(f);
        sent_map[seq] = 1'b1;
        while (low_free < SPACE && sent_map[low_free])
            low_free++;
    endtask

    // Mostly new frames near the edge, some repeats and some anywhere in the space
    task automatic queue_random_frames(input int count, input int win);
        int k;
        int r;
        int pick;
        int cand;
        int tries;
        for (k = 0; k < count; k++)
        begin
            r = $urandom_range(99);
            if (low_free >= SPACE)
                pick = $urandom_range(SPACE - 1);
            else if (r < 10 && low_free > 0)
                pick = low_free - 1 - $urandom_range(low_free > 16 ? 15 : low_free - 1);
            else if (r < 18)
                pick = $urandom_range(SPACE - 1);
            else
            begin
                pick = low_free;
                for (tries = 0; tries < 8; tries++)
                begin
                    cand = low_free + $urandom_range(win + 1);
                    if (cand < SPACE && !sent_map[cand])
                    begin
                        pick = cand;
                        break;
                    end
                end
            end
            queue_frame(pick, $urandom_range(255));
        end
    endtask

    // Fill the slots behind the first gap in shuffled order, then close the gap
    task automatic queue_window_burst(input int width);
        int slots [$];
        int k;
        int j;
        int tmp;
        int gap;
        gap = low_free;
        for (k = gap + 1; k < gap + width && k < SPACE; k++)
            if (!sent_map[k])
                slots.push_back(k);
        for (k = slots.size() - 1; k > 0; k--)
        begin
            j        = $urandom_range(k);
            tmp      = slots[k];
            slots[k] = slots[j];
            slots[j] = tmp;
        end
        foreach (slots[k])
            queue_frame(slots[k], $urandom_range(255));
        if (gap < SPACE)
            queue_frame(gap, $urandom_range(255));
    endtask

    // Wait until every frame is taken and every result is in, then let the block settle
    task automatic wait_drained();
        while (frame_q.size() != 0 || frame_ch.valid || window_out_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        window_copy = value;
    endtask

    // Drain, reconfigure and set the idling of the next phase
    task automatic start_phase(input logic [CFG_W-1:0] win, input int s_idle, input int r_stall);
        wait_drained();
        write_window(win);
        send_idle_pct  = s_idle;
        recv_stall_pct = r_stall;
    endtask

    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        frame_ch.valid     = 1'b0;
        frame_ch.seq_num   = '0;
        frame_ch.payload   = '0;
        result_ch.ready    = 1'b0;
        error_count        = 0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        hold_requests      = 0;
        hold_served        = 0;
        hold_left          = 0;
        frame_taken        = 1'b0;
        rx_edge            = 0;
        low_free           = 0;
        window_copy        = WIN_RESET;
        for (int k = 0; k < SPACE; k++)
        begin
            seen_map[k]   = 1'b0;
            byte_store[k] = '0;
            sent_map[k]   = 1'b0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Oversized window used as the maximum; far frame, gaps, repeats
        start_phase(6'd63, 0, 0);
        queue_frame(255, 8'hFF);
        queue_frame(2, 8'h00);
        queue_frame(1, 8'hA5);
        queue_frame(0, 8'h5A);
        queue_frame(1, 8'h33);
        queue_frame(255, 8'h00);
        queue_frame(3, 8'h80);
        queue_frame(5, 8'h01);
        queue_frame(4, 8'h7F);

        // Zero window used as one; edge stops past the window next to a filled slot
        start_phase(6'd0, 0, 0);
        queue_frame(7, 8'hFE);
        queue_frame(6, 8'hC3);
        queue_frame(0, 8'h11);
        queue_frame(8, 8'h00);

        // Whole window filled, edge moves past it
        start_phase(WIN_RESET, 0, 0);
        queue_frame(10, 8'h55);
        queue_frame(11, 8'hAA);
        queue_frame(12, 8'h0F);
        queue_frame(9, 8'hF0);

        // Largest window, full release in one frame, no idling
        start_phase(6'd32, 0, 0);
        queue_window_burst(32);
        queue_random_frames(35, 32);

        // Single-slot window, sender idle half the time
        start_phase(6'd1, 50, 0);
        queue_random_frames(40, 1);

        // Receiver stalls half the time and holds off long enough to back up the input
        start_phase(6'd20, 0, 50);
        hold_requests++;
        queue_random_frames(45, 20);

        // Both sides idle now and then
        start_phase(6'd7, 18, 18);
        queue_window_burst(7);
        queue_random_frames(35, 7);

        // Sweep the rest of the space so the edge saturates, then repeat frames at the end
        start_phase(6'd17, 18, 18);
        while (low_free < SPACE)
            queue_random_frames(1, 17);
        queue_frame(255, $urandom_range(255));
        queue_frame(0, $urandom_range(255));
        queue_random_frames(4, 17);

        wait_drained();
        if (error_count == 0 && window_out_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
